// ===== sv/ubdc_pkg.sv =====
package ubdc_pkg;

	localparam int DW = 40;          // dividend and quotient width of the divide pipes
	localparam int BAUD_W = 32;
	localparam int ERR_W = 7;
	localparam int CLK16_W = 28;
	localparam int FRAC_W = 7;
	localparam int DIVR_W = 23;      // int*64+frac for int up to 65536

	localparam logic [31:0] CLK_RESET = 32'd100000000;
	localparam logic [CLK16_W-1:0] DIV_LIMIT = 28'd65536;
	localparam logic [39:0] PCT_SCALE = 40'd100;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_HIGH  = 2'd1;
	localparam logic [1:0] ST_DIV_LARGE = 2'd2;
	localparam logic [1:0] ST_ERR_LARGE = 2'd3;

	typedef struct packed {
		logic [CLK16_W-1:0] clk16;
		logic [BAUD_W-1:0]  baud;
		logic [ERR_W-1:0]   max_err;
		logic               too_high;
		logic               too_large;
		logic [CLK16_W-1:0] ibdiv;
		logic [FRAC_W-1:0]  frac;
		logic [BAUD_W-1:0]  diff;
	} item_t;

endpackage

// ===== sv/ubdc_div.sv =====
module ubdc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [ubdc_pkg::DW-1:0] dividend,
	input  logic [31:0]          divisor,
	input  ubdc_pkg::item_t      in_item,
	output logic                 out_valid,
	output logic [ubdc_pkg::DW-1:0] quotient,
	output ubdc_pkg::item_t      out_item
);
	import ubdc_pkg::*;

	// entry 0 is the input side, entry i+1 the register of step i
	logic          v_s   [0:DW];
	logic [DW-1:0] dq_s  [0:DW];
	logic [31:0]   rem_s [0:DW];
	logic [31:0]   dv_s  [0:DW];
	item_t         it_s  [0:DW];

	assign v_s[0]   = in_valid;
	assign dq_s[0]  = dividend;
	assign rem_s[0] = '0;
	assign dv_s[0]  = divisor;
	assign it_s[0]  = in_item;

	for (genvar i = 0; i < DW; i++) begin : g_step
		logic [32:0] sh;
		logic        ge;
		logic [32:0] dif;
		assign sh  = {rem_s[i], dq_s[i][DW-1]};
		assign ge  = sh >= {1'b0, dv_s[i]};
		assign dif = sh - {1'b0, dv_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[i+1]  <= {dq_s[i][DW-2:0], ge};
				rem_s[i+1] <= ge ? dif[31:0] : sh[31:0];
				dv_s[i+1]  <= dv_s[i];
				it_s[i+1]  <= it_s[i];
			end
		end
	end

	assign out_valid = v_s[DW];
	assign quotient  = dq_s[DW];
	assign out_item  = it_s[DW];

endmodule

// ===== sv/uart_baud_divisor_calc_core.sv =====
// uart baud divisor calculator
// configuration: cfg_we with cfg_wdata sets the reference clock in hertz;
//   write it only while no request is in flight
// request channel s_*: one transfer carries a baud rate and an error limit
// result channel m_*: one transfer per request with status, integer divisor
//   and fractional divisor in sixty-fourths
// a request runs through three bit-per-stage divide pipes (40 stages each)
//   plus five staging registers: 125 cycles from request to result
// throughput is one request per cycle; the divide pipes set the latency
// reset empties the pipeline and loads a 100 MHz reference clock
// when m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated
module uart_baud_divisor_calc_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // baud_rate[31:0], max_error_percent[38:32], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[1:0], int_divisor[33:2], frac_divisor[40:34], zero
);
	import ubdc_pkg::*;

	logic [31:0] clock_hz_q;
	logic        en;

	logic        v_s1, v_s2, v_s3, v_s4;
	item_t       it_s1, it_s2, it_s3, it_s4;
	item_t       s1_nx, s2_nx, s3_nx;
	logic        d1_v, d2_v, d3_v;
	item_t       d1_it, d2_it, d3_it;
	logic [DW-1:0] d1_q, d2_q, d3_q;
	logic [DIVR_W-1:0] divr;
	logic [33:0] diff_w;

	logic [1:0]  status_q;
	logic [31:0] int_q;
	logic [6:0]  frac_q;
	logic        out_v_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLK_RESET;
		end else if (cfg_we) begin
			clock_hz_q <= cfg_wdata;
		end
	end

	// front stage: rate check
	always_comb begin
		s1_nx          = '0;
		s1_nx.clk16    = clock_hz_q[31:4];
		s1_nx.baud     = s_tdata[31:0];
		s1_nx.max_err  = s_tdata[38:32];
		// 16*baud > clk is the same as baud > clk/16 truncated
		s1_nx.too_high = (s_tdata[31:0] == '0) ||
			(s_tdata[31:0] > {4'b0, clock_hz_q[31:4]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= s1_nx;
		end
	end

	// q7 = (clk16 << 7) / baud
	ubdc_div u_div_q7 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1),
		.dividend({5'b0, it_s1.clk16, 7'b0}),
		.divisor(it_s1.baud),
		.in_item(it_s1),
		.out_valid(d1_v), .quotient(d1_q), .out_item(d1_it)
	);

	// integer part, rounded fraction, divisor limit
	always_comb begin
		s2_nx           = d1_it;
		s2_nx.ibdiv     = d1_q[34:7];
		s2_nx.frac      = {1'b0, d1_q[6:1]} + {6'b0, d1_q[0]};
		s2_nx.too_large = d1_q[34:7] > DIV_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= d1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= s2_nx;
		end
	end

	// combined divisor is a sum so a fraction of 64 carries into the integer
	assign divr = {it_s2.ibdiv[16:0], 6'b0} + {16'b0, it_s2.frac};

	// achieved rate = (clk16 << 6) / divisor
	ubdc_div u_div_rate (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2),
		.dividend({6'b0, it_s2.clk16, 6'b0}),
		.divisor({9'b0, divr}),
		.in_item(it_s2),
		.out_valid(d2_v), .quotient(d2_q), .out_item(d2_it)
	);

	assign diff_w = ({2'b0, d2_it.baud} > d2_q[33:0]) ?
		{2'b0, d2_it.baud} - d2_q[33:0] : d2_q[33:0] - {2'b0, d2_it.baud};

	always_comb begin
		s3_nx      = d2_it;
		s3_nx.diff = diff_w[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= d2_v;
			v_s4 <= v_s3;
		end
	end

	logic [39:0] prod_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3   <= s3_nx;
			it_s4   <= it_s3;
			prod_s4 <= {8'b0, it_s3.diff} * PCT_SCALE;
		end
	end

	// percent error = diff*100 / baud
	ubdc_div u_div_pct (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4),
		.dividend(prod_s4),
		.divisor(it_s4.baud),
		.in_item(it_s4),
		.out_valid(d3_v), .quotient(d3_q), .out_item(d3_it)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= d3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (d3_it.too_high) begin
				status_q <= ST_TOO_HIGH;
				int_q    <= '0;
				frac_q   <= '0;
			end else if (d3_it.too_large) begin
				status_q <= ST_DIV_LARGE;
				int_q    <= {4'b0, d3_it.ibdiv};
				frac_q   <= '0;
			end else begin
				status_q <= ({33'b0, d3_it.max_err} < d3_q) ? ST_ERR_LARGE : ST_OK;
				int_q    <= {4'b0, d3_it.ibdiv};
				frac_q   <= d3_it.frac;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'b0, frac_q, int_q, status_q};

endmodule

// ===== bench/tb_uart_baud_divisor_calc_core.sv =====
module tb_uart_baud_divisor_calc_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ubdc_pkg::*;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] int_div;
		logic [6:0]  frac_div;
	} divisor_t;

	// expected divisor results in request order
	class divisor_scoreboard;
		logic [31:0] ref_clk_hz;
		divisor_t    pending[$];
		int          errors;
		int          checked;

		function void reset_clock();
			ref_clk_hz = CLK_RESET;
		endfunction

		function void note_request(logic [31:0] baud, logic [6:0] max_err);
			divisor_t r;
			logic [63:0] c16, ib, q6, q7, fb, dv, calc, diff, pct;
			c16 = {32'd0, ref_clk_hz} / 64'd16;
			r.status = ST_TOO_HIGH;
			r.int_div = '0;
			r.frac_div = '0;
			if (baud == 0 || {32'd0, baud} * 64'd16 > {32'd0, ref_clk_hz}) begin
				pending.push_back(r);
				return;
			end
			ib = c16 / baud;
			r.int_div = ib[31:0];
			if (ib > 64'd65536) begin
				r.status = ST_DIV_LARGE;
				pending.push_back(r);
				return;
			end
			q7 = (c16 << 7) / baud;
			q6 = (c16 << 6) / baud;
			// fraction rounded by the extra quotient bit, may reach 64
			fb = (q6 & 64'h3F) + (q7 & 64'h1);
			r.frac_div = fb[6:0];
			dv = (ib << 6) + fb;
			calc = (dv != 0) ? (c16 << 6) / dv : 64'd0;
			diff = (baud > calc) ? baud - calc : calc - baud;
			pct = (diff * 64'd100) / baud;
			r.status = ({57'd0, max_err} < pct) ? ST_ERR_LARGE : ST_OK;
			pending.push_back(r);
		endfunction

		function void check_result(logic [47:0] d);
			divisor_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transfer %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (d[1:0] !== e.status) begin
				$error("status exp %0d got %0d", e.status, d[1:0]);
				errors++;
			end
			if (d[33:2] !== e.int_div) begin
				$error("int_divisor exp %0d got %0d", e.int_div, d[33:2]);
				errors++;
			end
			if (d[40:34] !== e.frac_div) begin
				$error("frac_divisor exp %0d got %0d", e.frac_div, d[40:34]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;

	divisor_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int cycles = 0;
	int requests = 0;
	int clock_writes = 0;
	localparam int LATENCY = 125;
	localparam int CYCLE_LIMIT = 1500000;

	uart_baud_divisor_calc_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[uart_baud_divisor_calc_core] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// s_tvalid stays high between back-to-back requests
	task automatic send_request(logic [31:0] baud, logic [6:0] max_err);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {1'b0, max_err, baud};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(baud, max_err);
		requests++;
	endtask

	task automatic write_clock(logic [31:0] hz);
		s_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= hz;
		@(posedge clk);
		cfg_we <= 0;
		sb.ref_clk_hz = hz;
		clock_writes++;
	endtask

	function automatic logic [31:0] pick_baud(logic [31:0] hz);
		logic [31:0] c16;
		c16 = hz / 16;
		case ($urandom_range(9))
			0: return $urandom();
			1: return $urandom_range(3);
			2: return (c16 > 0) ? c16 + $urandom_range(1) - 0 : 1;
			3: return (c16 / 65536) + $urandom_range(2);
			default: return (c16 > 1) ? $urandom_range(c16, 1) : 1;
		endcase
	endfunction

	task automatic random_phase(logic [31:0] hz, int n);
		logic [6:0] me;
		write_clock(hz);
		for (int i = 0; i < n; i++) begin
			me = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(5);
			send_request(pick_baud(hz), me);
		end
	endtask

	initial begin
		logic [31:0] std_rates[8];
		sb.reset_clock();
		std_rates = '{300, 9600, 19200, 115200, 460800, 921600, 3000000, 6250000};
		send_idle = 27;
		recv_idle = 69;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset clock: zero rate, top rate, just above, huge divisor, divisor limit edge, extremes
		send_request(0, 0);
		send_request(32'hFFFF_FFFF, 7'h7F);
		send_request(6250000, 0);
		send_request(6250001, 127);
		send_request(1, 0);
		send_request(95, 3);
		send_request(96, 3);
		foreach (std_rates[k])
			send_request(std_rates[k], 0);
		send_request(4000000, 0);
		send_request(4000000, 127);
		send_request(5000000, 10);
		write_clock(0);
		send_request(1, 127);
		send_request(0, 0);
		write_clock(32'hFFFF_FFFF);
		send_request(32'h0FFF_FFFF, 0);
		send_request(65535, 0);
		send_request(3, 1);
		write_clock(1);
		send_request(1, 0);
		send_request(0, 127);

		random_phase(100000000, 250);
		random_phase(32'hFFFF_FFFF, 200);
		send_idle = 69;
		recv_idle = 27;
		random_phase(16, 50);
		random_phase(1843200, 250);
		random_phase($urandom(), 200);
		send_idle = 0;
		recv_idle = 0;
		random_phase(48000000, 250);
		random_phase($urandom_range(100000, 16), 230);

		s_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d requests over %0d reference clock settings, checked %0d results",
			requests, clock_writes + 1, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[uart_baud_divisor_calc_core] OK");
		else
			$display("[uart_baud_divisor_calc_core] ERROR");
		$finish;
	end
endmodule
